// ===== src/i2c_master_bit_engine_defines.svh =====
// Assertion macros for the I2C master bit engine
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

// clocked check, off while reset is asserted
`define I2CBE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, also live during reset
`define I2CBE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/i2cbe_pkg.sv =====
// Shared types, command codes and slot tables for the I2C master bit engine
package i2cbe_pkg;

    localparam int PHASE_W = 10;
    localparam int DATA_W  = 8;
    localparam int FUNC_W  = 3;
    localparam int SLOT_W  = 5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FUNC_W-1:0] CMD_START   = 3'd0;
    localparam logic [FUNC_W-1:0] CMD_STOP    = 3'd1;
    localparam logic [FUNC_W-1:0] CMD_WRITE   = 3'd2;
    localparam logic [FUNC_W-1:0] CMD_READ    = 3'd3;
    localparam logic [FUNC_W-1:0] CMD_SENDACK = 3'd4;
    localparam logic [FUNC_W-1:0] CMD_GETACK  = 3'd5;

    localparam logic [PHASE_W-1:0] PHASE_RESET = 10'd5;

    localparam logic [SLOT_W-1:0] SLOTS_START = 5'd2;
    localparam logic [SLOT_W-1:0] SLOTS_STOP  = 5'd3;
    localparam logic [SLOT_W-1:0] SLOTS_WRITE = 5'd24;
    localparam logic [SLOT_W-1:0] SLOTS_READ  = 5'd16;
    localparam logic [SLOT_W-1:0] SLOTS_ACK   = 5'd2;

    // one tick word after classification
    typedef struct packed {
        logic              go;
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] load;
        logic              sda_in;
    } t_tick;

    // one result word
    typedef struct packed {
        logic              ack;
        logic [DATA_W-1:0] rd_data;
        logic              done;
        logic              busy;
        logic              sda_enable;
        logic              sda_level;
        logic              scl;
    } t_res;

    function automatic logic [SLOT_W-1:0] slot_total(input logic [FUNC_W-1:0] cmd);
        logic [SLOT_W-1:0] total;
        unique case (cmd)
            CMD_START: total = SLOTS_START;
            CMD_STOP:  total = SLOTS_STOP;
            CMD_WRITE: total = SLOTS_WRITE;
            CMD_READ:  total = SLOTS_READ;
            default:   total = SLOTS_ACK;
        endcase
        return total;
    endfunction

    // SCL-high slot that samples SDA
    function automatic logic slot_samples(input logic [FUNC_W-1:0] cmd,
                                          input logic [SLOT_W-1:0] s);
        logic hit;
        unique case (cmd)
            CMD_READ:   hit = s[0];
            CMD_GETACK: hit = (s == SLOT_W'(1));
            default:    hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ===== src/i2cbe_front.sv =====
// Front end: takes tick words, decodes the command and preloads the shift byte
`include "i2c_master_bit_engine_defines.svh"

module i2cbe_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [15:0]            i_s_tdata,  // wr_data[7:0], ack_to_send[8], sda_in[9]
    input  logic [3:0]             i_s_tuser,  // cmd_valid[0], func[3:1]
    input  logic                   i_full,
    output logic                   o_push,
    output i2cbe_pkg::t_tick       o_tick
);
    import i2cbe_pkg::*;

    logic              cmd_valid;
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] wr_data;
    logic              ack_to_send;

    assign cmd_valid   = i_s_tuser[0];
    assign func        = i_s_tuser[3:1];
    assign wr_data     = i_s_tdata[7:0];
    assign ack_to_send = i_s_tdata[8];

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;

    always_comb begin
        o_tick.go     = cmd_valid && (func <= CMD_GETACK);
        o_tick.func   = func;
        o_tick.sda_in = i_s_tdata[9];
        unique case (func)
            CMD_WRITE:   o_tick.load = wr_data;
            CMD_SENDACK: o_tick.load = {{(DATA_W-1){1'b0}}, ack_to_send};
            default:     o_tick.load = '0;
        endcase
    end

    // i_clk and i_rst_n only feed the checks below
    `I2CBE_ASSERT(a_front_no_push_full, i_clk, i_rst_n,
        i_full |-> !o_push, "front pushed into full queue")

endmodule

// ===== src/i2cbe_queue.sv =====
// Short register queue between front end and bus sequencer
module i2cbe_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  i2cbe_pkg::t_tick i_tick,
    output logic             o_full,
    output logic             o_valid,
    output i2cbe_pkg::t_tick o_head,
    input  logic             i_pop
);
    import i2cbe_pkg::*;

    t_tick             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_tick;
        end
    end

endmodule

// ===== src/i2cbe_back.sv =====
// Bus sequencer: slot timing, line drive, byte shifting and result register
`include "i2c_master_bit_engine_defines.svh"

module i2cbe_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [9:0]            i_cfg_wdata,
    input  logic                  i_valid,
    input  i2cbe_pkg::t_tick      i_tick,
    output logic                  o_pop,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output i2cbe_pkg::t_res       o_res
);
    import i2cbe_pkg::*;

    logic [PHASE_W-1:0] r_phase;
    logic [FUNC_W-1:0]  r_cmd, n_cmd;
    logic               r_busy, n_busy;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [1:0]         r_sub, n_sub;       // slot index mod 3
    logic [PHASE_W-1:0] r_tick, n_tick;
    logic [DATA_W-1:0]  r_shift, n_shift;
    logic               r_scl, n_scl;
    logic               r_sda, n_sda;
    logic               r_sda_en, n_sda_en;
    logic [DATA_W-1:0]  r_rd, n_rd;
    logic               r_ack, n_ack;
    logic               n_done;
    logic               r_out_valid;
    t_res               r_out;

    logic [PHASE_W-1:0] plen;
    logic [SLOT_W-1:0]  slot_inc;
    logic [1:0]         sub_inc;
    logic               do_slot;
    logic [FUNC_W-1:0]  s_cmd;
    logic [SLOT_W-1:0]  s_idx;
    logic [1:0]         s_sub;
    logic               fire;

    assign plen     = (r_phase == '0) ? PHASE_W'(1) : r_phase;
    assign slot_inc = r_slot + SLOT_W'(1);
    assign sub_inc  = (r_sub == 2'd2) ? 2'd0 : r_sub + 2'd1;
    assign fire     = i_valid && (!r_out_valid || i_m_tready);
    assign o_pop    = fire;

    always_comb begin
        n_cmd    = r_cmd;
        n_busy   = r_busy;
        n_slot   = r_slot;
        n_sub    = r_sub;
        n_tick   = r_tick;
        n_shift  = r_shift;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_sda_en = r_sda_en;
        n_rd     = r_rd;
        n_ack    = r_ack;
        n_done   = 1'b0;
        do_slot  = 1'b0;
        s_cmd    = r_cmd;
        s_idx    = slot_inc;
        s_sub    = sub_inc;

        if (r_busy) begin
            if (r_tick >= plen) begin
                n_slot = slot_inc;
                n_sub  = sub_inc;
                n_tick = PHASE_W'(1);
                if (slot_inc >= slot_total(r_cmd)) begin
                    if (r_cmd != CMD_STOP) begin
                        n_scl = 1'b0;
                    end
                    if (r_cmd == CMD_READ) begin
                        n_rd = r_shift;
                    end
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end else begin
                    do_slot = 1'b1;
                end
            end else begin
                n_tick = r_tick + PHASE_W'(1);
            end
        end else if (i_tick.go) begin
            n_cmd   = i_tick.func;
            n_busy  = 1'b1;
            n_slot  = '0;
            n_sub   = 2'd0;
            n_tick  = PHASE_W'(1);
            n_shift = i_tick.load;
            do_slot = 1'b1;
            s_cmd   = i_tick.func;
            s_idx   = '0;
            s_sub   = 2'd0;
        end

        if (do_slot) begin
            unique case (s_cmd)
                CMD_START: begin
                    if (s_idx == '0) begin
                        n_sda_en = 1'b1;
                        n_sda    = 1'b1;
                        n_scl    = 1'b1;
                    end else begin
                        n_sda = 1'b0;
                    end
                end
                CMD_STOP: begin
                    if (s_idx == '0) begin
                        n_sda_en = 1'b1;
                        n_scl    = 1'b0;
                        n_sda    = 1'b0;
                    end else if (s_idx == SLOT_W'(1)) begin
                        n_scl = 1'b1;
                    end else begin
                        n_sda = 1'b1;
                    end
                end
                CMD_WRITE: begin
                    if (s_idx == '0) begin
                        n_sda_en = 1'b1;
                    end
                    if (s_sub == 2'd0) begin
                        n_scl = 1'b0;
                    end else if (s_sub == 2'd1) begin
                        n_sda   = n_shift[DATA_W-1];
                        n_shift = {n_shift[DATA_W-2:0], 1'b0};
                    end else begin
                        n_scl = 1'b1;
                    end
                end
                CMD_READ: begin
                    if (s_idx == '0) begin
                        n_sda_en = 1'b0;
                    end
                    n_scl = s_idx[0];
                end
                CMD_SENDACK: begin
                    if (s_idx == '0) begin
                        n_scl    = 1'b0;
                        n_sda_en = 1'b1;
                        n_sda    = n_shift[0];
                    end else begin
                        n_scl = 1'b1;
                    end
                end
                default: begin
                    if (s_idx == '0) begin
                        n_scl    = 1'b0;
                        n_sda_en = 1'b0;
                    end else begin
                        n_scl = 1'b1;
                    end
                end
            endcase
        end

        if (n_busy && (n_tick == plen) && slot_samples(n_cmd, n_slot)) begin
            if (n_cmd == CMD_READ) begin
                n_shift = {n_shift[DATA_W-2:0], i_tick.sda_in};
            end else begin
                n_ack = i_tick.sda_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PHASE_RESET;
            r_cmd       <= CMD_START;
            r_busy      <= 1'b0;
            r_slot      <= '0;
            r_sub       <= 2'd0;
            r_tick      <= '0;
            r_shift     <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_sda_en    <= 1'b1;
            r_rd        <= '0;
            r_ack       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_phase <= i_cfg_wdata;
            end
            if (fire) begin
                r_cmd       <= n_cmd;
                r_busy      <= n_busy;
                r_slot      <= n_slot;
                r_sub       <= n_sub;
                r_tick      <= n_tick;
                r_shift     <= n_shift;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_sda_en    <= n_sda_en;
                r_rd        <= n_rd;
                r_ack       <= n_ack;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.scl        <= n_scl;
            r_out.sda_level  <= n_sda;
            r_out.sda_enable <= n_sda_en;
            r_out.busy       <= n_busy;
            r_out.done       <= n_done;
            r_out.rd_data    <= n_rd;
            r_out.ack        <= n_ack;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_res      = r_out;

    `I2CBE_ASSERT(a_done_not_busy, i_clk, i_rst_n,
        (r_out_valid && r_out.done) |-> !r_out.busy, "done word still shows busy")
    `I2CBE_ASSERT(a_tick_in_slot, i_clk, i_rst_n,
        r_busy |-> ((r_tick != '0) && (r_tick <= plen)), "slot tick count out of range")
    `I2CBE_ASSERT(a_slot_in_cmd, i_clk, i_rst_n,
        r_busy |-> (r_slot < slot_total(r_cmd)), "slot index past end of command")
    `I2CBE_ASSERT(a_sub_mod3, i_clk, i_rst_n,
        r_busy |-> (r_sub != 2'd3), "bit phase counter out of range")

endmodule

// ===== src/i2c_master_bit_engine.sv =====
// I2C master bit engine top level: front end, tick queue and bus sequencer
// A tick word is queued, then moves from the queue head into the result register.
// Throughput: one tick word per cycle while the output is not stalled; the two-entry
// queue and the result register let input and output stall independently.
// Reset (synchronous, active low): bus idle with SCL and SDA high and driven,
// slot length 5 ticks, queue and result register empty.
module i2c_master_bit_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [9:0]  i_cfg_wdata,   // phase_length
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,     // wr_data[7:0], ack_to_send[8], sda_in[9]
    input  logic [3:0]  i_s_tuser,     // cmd_valid[0], func[3:1]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata      // scl[0], sda_level[1], sda_enable[2], busy[3],
                                       // done[4], rd_data[12:5], ack_received[13]
);
    import i2cbe_pkg::*;

    t_tick push_tick;
    t_tick head_tick;
    t_res  res;
    logic  push;
    logic  full;
    logic  head_valid;
    logic  pop;

    i2cbe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_full     (full),
        .o_push     (push),
        .o_tick     (push_tick)
    );

    i2cbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tick  (push_tick),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head_tick),
        .i_pop   (pop)
    );

    i2cbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (head_valid),
        .i_tick      (head_tick),
        .o_pop       (pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_res       (res)
    );

    assign o_m_tdata = {2'b00, res.ack, res.rd_data, res.done, res.busy,
                        res.sda_enable, res.sda_level, res.scl};

endmodule
